>>> rtl/core/hapseq_pkg.sv
// Package for the haptic alert pattern sequencer.
// Holds the word types, the phase and command codes and the register map.
// No dependencies.
`default_nettype none
package hapseq_pkg;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SETUP = 3'd1,
		PH_PULSE = 3'd2,
		PH_ON    = 3'd3,
		PH_OFF   = 3'd4,
		PH_GAP   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		FN_TICK  = 3'd0,
		FN_MSG   = 3'd1,
		FN_IDLE  = 3'd2,
		FN_HR    = 3'd3,
		FN_STOP  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		REG_ON_TIME     = 3'd0,
		REG_OFF_TIME    = 3'd1,
		REG_ROUND_GAP   = 3'd2,
		REG_SHORT_BURST = 3'd3,
		REG_LONG_BURST  = 3'd4,
		REG_CALL_ROUNDS = 3'd5,
		REG_IDLE_ROUNDS = 3'd6,
		REG_HR_ROUNDS   = 3'd7
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;
	localparam logic [3:0]  MSG_OTHER_ROUNDS = 4'd1;

	localparam logic [15:0] RST_ON_TIME     = 16'd100;
	localparam logic [15:0] RST_OFF_TIME    = 16'd400;
	localparam logic [15:0] RST_ROUND_GAP   = 16'd2000;
	localparam logic [3:0]  RST_SHORT_BURST = 4'd2;
	localparam logic [3:0]  RST_LONG_BURST  = 4'd3;
	localparam logic [3:0]  RST_CALL_ROUNDS = 4'd3;
	localparam logic [3:0]  RST_IDLE_ROUNDS = 4'd3;
	localparam logic [3:0]  RST_HR_ROUNDS   = 4'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] now_ms;
		logic        update_mode;
		logic        incoming_call;
		logic        worn;
		logic        asleep;
	} in_word_t;

	typedef struct packed {
		logic       motor_on;
		logic       alert_active;
		logic [2:0] phase;
	} out_word_t;

	typedef struct packed {
		logic [15:0] on_time_ms;
		logic [15:0] off_time_ms;
		logic [15:0] round_gap_ms;
		logic [3:0]  short_burst_pulses;
		logic [3:0]  long_burst_pulses;
		logic [3:0]  call_rounds;
		logic [3:0]  idle_rounds;
		logic [3:0]  hr_rounds;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic        motor;
		logic [31:0] stamp_ms;
		logic [3:0]  pulses_done;
		logic [3:0]  rounds_done;
		logic [3:0]  pulse_limit;
		logic [3:0]  round_limit;
	} seq_state_t;

endpackage
`default_nettype wire

>>> rtl/core/haptic_alert_pattern_sequencer_unit.sv
// Top level of the haptic alert pattern sequencer: ports, register file, pipeline.
// Depends on hapseq_pkg and hapseq_step.
//
// This unit drives a vibration motor in bursts of pulses grouped into reminder
// rounds. Each input word is either a millisecond tick carrying the current
// wrapping time, a start command (message, inactivity alert, heart-rate alert)
// or a stop. Every input word yields exactly one output word that shows the
// motor level, whether a pattern is running, and the current phase after the
// word has acted. The datapath has two register stages: an input register and
// an output register, with the next-state logic (one 32-bit elapsed-time
// subtract and compare plus small counter updates) between them. A word thus
// passes the input register and then the output register, and the unit takes a
// new word in every cycle as long as the output side keeps taking words; when
// the output stalls, the input register still fills so one more word is taken.
// Timing registers and burst and round counts are written through the APB-style
// port at byte addresses 4*i; writes must only happen while the unit has no
// words in flight. There is no clearing pass after reset.
`default_nettype none
module haptic_alert_pattern_sequencer_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire hapseq_pkg::in_word_t             in_word,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output hapseq_pkg::out_word_t                 out_word,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire [hapseq_pkg::ADDR_W-1:0]          paddr,
	input  wire [31:0]                            pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	hapseq_pkg::cfg_t       cfg_q;
	hapseq_pkg::seq_state_t state_q;
	hapseq_pkg::seq_state_t state_nxt;
	hapseq_pkg::in_word_t   item_s1;
	logic                   valid_s1;
	logic                   advance;
	logic                   cfg_wr;
	hapseq_pkg::reg_idx_t   reg_idx;

	// Configuration port: always ready, register chosen by the word address.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = hapseq_pkg::reg_idx_t'(paddr[hapseq_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_time_ms         <= hapseq_pkg::RST_ON_TIME;
			cfg_q.off_time_ms        <= hapseq_pkg::RST_OFF_TIME;
			cfg_q.round_gap_ms       <= hapseq_pkg::RST_ROUND_GAP;
			cfg_q.short_burst_pulses <= hapseq_pkg::RST_SHORT_BURST;
			cfg_q.long_burst_pulses  <= hapseq_pkg::RST_LONG_BURST;
			cfg_q.call_rounds        <= hapseq_pkg::RST_CALL_ROUNDS;
			cfg_q.idle_rounds        <= hapseq_pkg::RST_IDLE_ROUNDS;
			cfg_q.hr_rounds          <= hapseq_pkg::RST_HR_ROUNDS;
		end else if (cfg_wr) begin
			case (reg_idx)
				hapseq_pkg::REG_ON_TIME:     cfg_q.on_time_ms         <= pwdata[15:0];
				hapseq_pkg::REG_OFF_TIME:    cfg_q.off_time_ms        <= pwdata[15:0];
				hapseq_pkg::REG_ROUND_GAP:   cfg_q.round_gap_ms       <= pwdata[15:0];
				hapseq_pkg::REG_SHORT_BURST: cfg_q.short_burst_pulses <= pwdata[3:0];
				hapseq_pkg::REG_LONG_BURST:  cfg_q.long_burst_pulses  <= pwdata[3:0];
				hapseq_pkg::REG_CALL_ROUNDS: cfg_q.call_rounds        <= pwdata[3:0];
				hapseq_pkg::REG_IDLE_ROUNDS: cfg_q.idle_rounds        <= pwdata[3:0];
				hapseq_pkg::REG_HR_ROUNDS:   cfg_q.hr_rounds          <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// Read data is zero-extended from the register's width.
	always_comb begin
		case (reg_idx)
			hapseq_pkg::REG_ON_TIME:     prdata = {16'd0, cfg_q.on_time_ms};
			hapseq_pkg::REG_OFF_TIME:    prdata = {16'd0, cfg_q.off_time_ms};
			hapseq_pkg::REG_ROUND_GAP:   prdata = {16'd0, cfg_q.round_gap_ms};
			hapseq_pkg::REG_SHORT_BURST: prdata = {28'd0, cfg_q.short_burst_pulses};
			hapseq_pkg::REG_LONG_BURST:  prdata = {28'd0, cfg_q.long_burst_pulses};
			hapseq_pkg::REG_CALL_ROUNDS: prdata = {28'd0, cfg_q.call_rounds};
			hapseq_pkg::REG_IDLE_ROUNDS: prdata = {28'd0, cfg_q.idle_rounds};
			hapseq_pkg::REG_HR_ROUNDS:   prdata = {28'd0, cfg_q.hr_rounds};
			default:                     prdata = 32'd0;
		endcase
	end

	// The word in the input register moves on when the output register is
	// empty or is being emptied in this cycle. The input register refills in
	// the same cycle, so flow is one word per cycle.
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_word;
		end
	end

	hapseq_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt)
	);

	// Sequencer state only changes when a word leaves the input register, so
	// every word acts on the state left by the word before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= hapseq_pkg::PH_IDLE;
			state_q.motor       <= 1'b0;
			state_q.stamp_ms    <= 32'd0;
			state_q.pulses_done <= 4'd0;
			state_q.rounds_done <= 4'd0;
			state_q.pulse_limit <= 4'd0;
			state_q.round_limit <= 4'd0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_word.motor_on     <= state_nxt.motor;
			out_word.alert_active <= (state_nxt.phase != hapseq_pkg::PH_IDLE);
			out_word.phase        <= state_nxt.phase;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/hapseq_step.sv
// Next-state logic of the haptic alert sequencer for one input word.
// Depends on hapseq_pkg.
`default_nettype none
module hapseq_step (
	input  wire hapseq_pkg::seq_state_t cur,
	input  wire hapseq_pkg::cfg_t       cfg,
	input  wire hapseq_pkg::in_word_t   item,
	output hapseq_pkg::seq_state_t      nxt
);

	logic [31:0] elapsed;
	logic [3:0]  pulses_inc;
	logic [3:0]  rounds_inc;

	assign elapsed    = item.now_ms - cur.stamp_ms;
	assign pulses_inc = (cur.pulses_done == 4'hF) ? 4'hF : cur.pulses_done + 4'd1;
	assign rounds_inc = (cur.rounds_done == 4'hF) ? 4'hF : cur.rounds_done + 4'd1;

	always_comb begin
		nxt = cur;
		case (item.func)
			hapseq_pkg::FN_TICK: begin
				if (item.update_mode) begin
					nxt.phase = hapseq_pkg::PH_IDLE;
					nxt.motor = 1'b0;
				end else begin
					case (cur.phase)
						hapseq_pkg::PH_IDLE: begin
						end
						hapseq_pkg::PH_SETUP: begin
							nxt.rounds_done = 4'd0;
							nxt.phase       = hapseq_pkg::PH_PULSE;
						end
						hapseq_pkg::PH_PULSE: begin
							nxt.stamp_ms = item.now_ms;
							nxt.motor    = 1'b1;
							nxt.phase    = hapseq_pkg::PH_ON;
						end
						hapseq_pkg::PH_ON: begin
							if (elapsed > {16'd0, cfg.on_time_ms}) begin
								nxt.motor       = 1'b0;
								nxt.stamp_ms    = item.now_ms;
								nxt.pulses_done = pulses_inc;
								nxt.phase       = hapseq_pkg::PH_OFF;
							end
						end
						hapseq_pkg::PH_OFF: begin
							if (elapsed > {16'd0, cfg.off_time_ms}) begin
								if (cur.pulses_done >= cur.pulse_limit) begin
									nxt.rounds_done = rounds_inc;
									nxt.stamp_ms    = item.now_ms;
									nxt.phase       = hapseq_pkg::PH_GAP;
								end else begin
									nxt.phase = hapseq_pkg::PH_PULSE;
								end
							end
						end
						hapseq_pkg::PH_GAP: begin
							if (elapsed > {16'd0, cfg.round_gap_ms}) begin
								if (cur.rounds_done >= cur.round_limit) begin
									nxt.phase = hapseq_pkg::PH_IDLE;
									nxt.motor = 1'b0;
								end else begin
									nxt.pulses_done = 4'd0;
									nxt.phase       = hapseq_pkg::PH_PULSE;
								end
							end
						end
						default: begin
							nxt.phase = hapseq_pkg::PH_IDLE;
							nxt.motor = 1'b0;
						end
					endcase
				end
			end
			hapseq_pkg::FN_MSG: begin
				if (item.worn && !item.asleep) begin
					nxt.pulses_done = 4'd0;
					nxt.pulse_limit = cfg.short_burst_pulses;
					nxt.round_limit = item.incoming_call ? cfg.call_rounds
						: hapseq_pkg::MSG_OTHER_ROUNDS;
					nxt.phase       = hapseq_pkg::PH_SETUP;
				end
			end
			hapseq_pkg::FN_IDLE: begin
				nxt.pulses_done = 4'd0;
				nxt.pulse_limit = cfg.short_burst_pulses;
				nxt.round_limit = cfg.idle_rounds;
				nxt.phase       = hapseq_pkg::PH_SETUP;
			end
			hapseq_pkg::FN_HR: begin
				nxt.pulses_done = 4'd0;
				nxt.pulse_limit = cfg.long_burst_pulses;
				nxt.round_limit = cfg.hr_rounds;
				nxt.phase       = hapseq_pkg::PH_SETUP;
			end
			hapseq_pkg::FN_STOP: begin
				nxt.phase = hapseq_pkg::PH_IDLE;
				nxt.motor = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/hapseq_checker.sv
// Port-level assertions for the haptic alert pattern sequencer, and their bind.
// Depends on hapseq_pkg and haptic_alert_pattern_sequencer_unit.
`default_nettype none
module hapseq_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_ready,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire hapseq_pkg::out_word_t out_word,
	input wire                        pready
);

	// The activity flag always agrees with the phase it is shown with.
	a_active_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.alert_active ==
			(out_word.phase != hapseq_pkg::PH_IDLE)))
		else $error("alert_active disagrees with phase");

	// The motor is never driven while idle, in the off pause or in the round gap.
	a_motor_off_when_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.motor_on) |->
			(out_word.phase != hapseq_pkg::PH_IDLE &&
			 out_word.phase != hapseq_pkg::PH_OFF &&
			 out_word.phase != hapseq_pkg::PH_GAP))
		else $error("motor on in a quiet phase");

	// An empty output side never holds back the input.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A stalled result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
		else $error("output word changed while stalled");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind haptic_alert_pattern_sequencer_unit hapseq_checker u_hapseq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word),
	.pready    (pready)
);
`default_nettype wire

>>> tb/haptic_alert_pattern_sequencer_unit_tb.sv
// Self-checking testbench for the haptic alert pattern sequencer top level.
// Depends on hapseq_pkg and haptic_alert_pattern_sequencer_unit; a built-in
// sequencer predictor checks every output word against the expected drive state.
module haptic_alert_pattern_sequencer_unit_tb;
	import hapseq_pkg::*;

	// Function codes five to seven are unused by the block and must be ignored.
	localparam logic [2:0] FN_UNUSED_LO = 3'd5;
	localparam logic [2:0] FN_UNUSED_HI = 3'd7;
	// Cycles without any accepted word (while something is pending) before giving up.
	localparam int STALL_LIMIT = 1000;
	// Length of the deliberate output hold-off that backs the pipeline up.
	localparam int HOLD_CYCLES = 80;
	// Random words per register setting.
	localparam int WORDS_PER_SETTING = 300;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t res;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_word_t            in_word;
	logic                out_valid;
	logic                out_ready;
	out_word_t           out_word;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// Predictor copy of the register file and of the sequencer state.
	cfg_t                timing_cfg;
	seq_state_t          seq;

	// Expected output words, oldest first.
	out_word_t           expected_drive_q[$];

	// Hand-typed expectation that travels with the word currently on the input.
	bit                  word_typed;
	out_word_t           word_typed_res;

	int                  error_count;
	int                  burst_left;
	bit                  hold_req;
	logic [31:0]         clock_ms;

	haptic_alert_pattern_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Loads a new pattern: fresh pulse count and limits, then the setup phase.
	task automatic arm_pattern(input logic [3:0] pulses, input logic [3:0] rounds);
		seq.pulses_done = 4'd0;
		seq.pulse_limit = pulses;
		seq.round_limit = rounds;
		seq.phase       = PH_SETUP;
	endtask

	// Advances the predicted sequencer by one input word and returns the
	// drive state that the block must report for it. Timeouts compare the
	// wrapping elapsed time with a strict greater-than, so a tick that lands
	// exactly on the configured time does not yet move the phase.
	task automatic advance_sequencer(input in_word_t w, output out_word_t drive);
		logic [31:0] elapsed;
		elapsed = w.now_ms - seq.stamp_ms;
		case (w.func)
			FN_TICK: begin
				if (w.update_mode) begin
					// A firmware update parks the sequencer with the motor off.
					seq.phase = PH_IDLE;
					seq.motor = 1'b0;
				end else begin
					case (seq.phase)
						PH_IDLE: begin
						end
						PH_SETUP: begin
							seq.rounds_done = 4'd0;
							seq.phase       = PH_PULSE;
						end
						PH_PULSE: begin
							seq.stamp_ms = w.now_ms;
							seq.motor    = 1'b1;
							seq.phase    = PH_ON;
						end
						PH_ON: begin
							if (elapsed > {16'd0, timing_cfg.on_time_ms}) begin
								seq.motor       = 1'b0;
								seq.stamp_ms    = w.now_ms;
								seq.pulses_done = (seq.pulses_done == 4'd15) ?
									seq.pulses_done : seq.pulses_done + 4'd1;
								seq.phase       = PH_OFF;
							end
						end
						PH_OFF: begin
							if (elapsed > {16'd0, timing_cfg.off_time_ms}) begin
								if (seq.pulses_done >= seq.pulse_limit) begin
									seq.rounds_done = (seq.rounds_done == 4'd15) ?
										seq.rounds_done : seq.rounds_done + 4'd1;
									seq.stamp_ms    = w.now_ms;
									seq.phase       = PH_GAP;
								end else begin
									seq.phase = PH_PULSE;
								end
							end
						end
						PH_GAP: begin
							if (elapsed > {16'd0, timing_cfg.round_gap_ms}) begin
								if (seq.rounds_done >= seq.round_limit) begin
									seq.phase = PH_IDLE;
									seq.motor = 1'b0;
								end else begin
									seq.pulses_done = 4'd0;
									seq.phase       = PH_PULSE;
								end
							end
						end
						default: begin
							seq.phase = PH_IDLE;
							seq.motor = 1'b0;
						end
					endcase
				end
			end
			FN_MSG: begin
				// Messages only buzz on a worn unit with an awake wearer.
				if (w.worn && !w.asleep) begin
					arm_pattern(timing_cfg.short_burst_pulses,
						w.incoming_call ? timing_cfg.call_rounds : MSG_OTHER_ROUNDS);
				end
			end
			FN_IDLE: arm_pattern(timing_cfg.short_burst_pulses, timing_cfg.idle_rounds);
			FN_HR:   arm_pattern(timing_cfg.long_burst_pulses, timing_cfg.hr_rounds);
			FN_STOP: begin
				seq.phase = PH_IDLE;
				seq.motor = 1'b0;
			end
			default: begin
			end
		endcase
		drive.motor_on     = seq.motor;
		drive.alert_active = (seq.phase != PH_IDLE);
		drive.phase        = seq.phase;
	endtask

	// Input acceptance feeds the predictor; output acceptance is checked against
	// the oldest expectation. Both sample at the rising edge, while the testbench
	// only drives at the falling edge, so the order of events cannot matter.
	always @(posedge clk) begin : drive_check
		out_word_t predicted;
		out_word_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				advance_sequencer(in_word, predicted);
				expected_drive_q.push_back(word_typed ? word_typed_res : predicted);
			end
			if (out_valid && out_ready) begin
				if (expected_drive_q.size() == 0) begin
					$error("output word %0h arrived with no expectation pending", out_word);
					error_count++;
				end else begin
					want = expected_drive_q.pop_front();
					if (out_word.motor_on !== want.motor_on) begin
						$error("motor_on: expected %0d, got %0d", want.motor_on,
							out_word.motor_on);
						error_count++;
					end
					if (out_word.alert_active !== want.alert_active) begin
						$error("alert_active: expected %0d, got %0d", want.alert_active,
							out_word.alert_active);
						error_count++;
					end
					if (out_word.phase !== want.phase) begin
						$error("phase: expected %0d, got %0d", want.phase, out_word.phase);
						error_count++;
					end
				end
			end
		end
	end

	// The output side stalls on a pattern of its own: long stretches of full
	// throughput, coin-flip stalls, sparse acceptance and strict alternation.
	// When asked, it also holds off for a long stretch so that the block fills
	// up and has to push back on its input.
	initial begin : output_stall_pattern
		int mode;
		int len;
		int k;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(10, 120);
			for (k = 0; k < len; k++) begin
				@(negedge clk);
				if (hold_req) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_req = 1'b0;
				end
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= $urandom_range(0, 1);
					2:       out_ready <= (k % 4 == 0);
					default: out_ready <= k[0];
				endcase
			end
		end
	end

	// Watchdog: a run that stops accepting words while something is still
	// pending has hung. Register writes and fully idle stretches do not count.
	initial begin : hang_watch
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel ||
				(expected_drive_q.size() == 0 && !in_valid)) begin
				stalled = 0;
			end else begin
				stalled++;
			end
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offers one word and returns at the falling edge after it has been taken.
	// Words go out in bursts of random length; between bursts valid drops for a
	// random gap, and about a quarter of the bursts follow on with no gap at all.
	task automatic send_word(input in_word_t w, input bit has_typed, input out_word_t typed);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid       <= 1'b1;
		in_word        <= w;
		word_typed     <= has_typed;
		word_typed_res <= typed;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Stops offering words and waits until every expected word has come back,
	// then a few more cycles so the pipeline is certainly empty.
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (expected_drive_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		burst_left = 0;
	endtask

	// One register write: setup cycle, then access cycle; the register takes
	// the value at the rising edge where the access phase meets pready. The
	// predictor keeps only the register's width, as the block does.
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ON_TIME:     timing_cfg.on_time_ms         = value[15:0];
			REG_OFF_TIME:    timing_cfg.off_time_ms        = value[15:0];
			REG_ROUND_GAP:   timing_cfg.round_gap_ms       = value[15:0];
			REG_SHORT_BURST: timing_cfg.short_burst_pulses = value[3:0];
			REG_LONG_BURST:  timing_cfg.long_burst_pulses  = value[3:0];
			REG_CALL_ROUNDS: timing_cfg.call_rounds        = value[3:0];
			REG_IDLE_ROUNDS: timing_cfg.idle_rounds        = value[3:0];
			default:         timing_cfg.hr_rounds          = value[3:0];
		endcase
		@(negedge clk);
	endtask

	function automatic dir_row_t mk_row(input logic [2:0] f, input logic [31:0] now,
		input bit upd, input bit call, input bit worn, input bit asleep,
		input bit typed, input bit motor, input bit active, input phase_t ph);
		dir_row_t r;
		r.w.func             = f;
		r.w.now_ms           = now;
		r.w.update_mode      = upd;
		r.w.incoming_call    = call;
		r.w.worn             = worn;
		r.w.asleep           = asleep;
		r.typed              = typed;
		r.res.motor_on       = motor;
		r.res.alert_active   = active;
		r.res.phase          = ph;
		return r;
	endfunction

	initial begin : main_flow
		dir_row_t    dir_rows[$];
		in_word_t    w;
		cfg_t        setting;
		logic [31:0] thr;
		logic [31:0] target;
		logic [31:0] diff;
		int          pick;
		int          start_pct;
		int          n;
		int          p;

		// Every block input is known from time zero.
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_word        = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		word_typed     = 1'b0;
		word_typed_res = '0;
		error_count    = 0;
		burst_left     = 0;
		hold_req       = 1'b0;

		// Predictor state after reset.
		timing_cfg = '{RST_ON_TIME, RST_OFF_TIME, RST_ROUND_GAP, RST_SHORT_BURST,
			RST_LONG_BURST, RST_CALL_ROUNDS, RST_IDLE_ROUNDS, RST_HR_ROUNDS};
		seq = '{PH_IDLE, 1'b0, 32'd0, 4'd0, 4'd0, 4'd0, 4'd0};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, run with the reset register values (on 100 ms, off 400 ms).
		// Columns: func, now, update, call, worn, asleep, typed?, motor, active, phase.
		// A tick right after reset leaves the sequencer idle.
		dir_rows.push_back(mk_row(FN_TICK, 32'd0, 0, 0, 0, 0, 1, 0, 0, PH_IDLE));
		// Unused function codes are ignored, with every flag and time bit high or low.
		dir_rows.push_back(mk_row(FN_UNUSED_LO, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_UNUSED_HI, 32'd0, 0, 0, 0, 0, 1, 0, 0, PH_IDLE));
		// A message on an unworn unit, or with a sleeping wearer, is dropped.
		dir_rows.push_back(mk_row(FN_MSG, 32'd5, 0, 1, 0, 0, 1, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_MSG, 32'd5, 0, 1, 1, 1, 1, 0, 0, PH_IDLE));
		// An incoming call on a worn unit starts the pattern.
		dir_rows.push_back(mk_row(FN_MSG, 32'd10, 0, 1, 1, 0, 1, 0, 1, PH_SETUP));
		dir_rows.push_back(mk_row(FN_TICK, 32'd10, 0, 0, 0, 0, 1, 0, 1, PH_PULSE));
		dir_rows.push_back(mk_row(FN_TICK, 32'd20, 0, 0, 0, 0, 1, 1, 1, PH_ON));
		// Exactly the on time elapsed is not yet a timeout; one more millisecond is.
		dir_rows.push_back(mk_row(FN_TICK, 32'd120, 0, 0, 0, 0, 0, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_TICK, 32'd121, 0, 0, 0, 0, 0, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_TICK, 32'd522, 0, 0, 0, 0, 0, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_TICK, 32'd530, 0, 0, 0, 0, 0, 0, 0, PH_IDLE));
		// A restart while the motor runs keeps the motor on.
		dir_rows.push_back(mk_row(FN_HR, 32'd531, 0, 0, 0, 0, 0, 0, 0, PH_IDLE));
		// Update mode on a tick forces idle with the motor off.
		dir_rows.push_back(mk_row(FN_TICK, 32'd532, 1, 0, 0, 0, 1, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_IDLE, 32'd533, 0, 0, 0, 0, 1, 0, 1, PH_SETUP));
		dir_rows.push_back(mk_row(FN_TICK, 32'd534, 0, 0, 0, 0, 0, 0, 0, PH_IDLE));
		// The on time runs across the wrap of the millisecond counter.
		dir_rows.push_back(mk_row(FN_TICK, 32'hFFFF_FFF0, 0, 0, 0, 0, 1, 1, 1, PH_ON));
		dir_rows.push_back(mk_row(FN_TICK, 32'h0000_0054, 0, 0, 0, 0, 0, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_TICK, 32'h0000_0055, 0, 0, 0, 0, 0, 0, 0, PH_IDLE));
		// A plain message (not a call) restarts with a single round.
		dir_rows.push_back(mk_row(FN_MSG, 32'h0000_0056, 0, 0, 1, 0, 0, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_STOP, 32'h0000_0057, 0, 0, 0, 0, 1, 0, 0, PH_IDLE));
		// Update mode on a command is not looked at: the command still acts,
		// and the next tick with update mode set parks the sequencer.
		dir_rows.push_back(mk_row(FN_HR, 32'h0000_0058, 1, 0, 0, 0, 0, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_TICK, 32'h0000_0059, 1, 0, 0, 0, 1, 0, 0, PH_IDLE));
		dir_rows.push_back(mk_row(FN_STOP, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 0, 0, PH_IDLE));

		foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
		drain_outputs();

		// Random part: several register settings, each written while the block
		// is empty. They cover fast and slow timing, the one-pulse one-round
		// minimum, the fifteen-pulse fifteen-round maximum, zero limits (a burst
		// or a sequence then ends after one pulse or one round) and a random mix.
		for (p = 0; p < 6; p++) begin
			case (p)
				0: setting = '{16'd3, 16'd5, 16'd7, 4'd2, 4'd3, 4'd2, 4'd3, 4'd2};
				1: setting = '{16'd1, 16'd1, 16'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1};
				2: setting = '{16'd1, 16'd1, 16'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15};
				3: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd2, 4'd3, 4'd1, 4'd2, 4'd1};
				4: setting = '{16'd0, 16'd0, 16'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
				default: begin
					setting.on_time_ms         = $urandom_range(1, 40);
					setting.off_time_ms        = $urandom_range(1, 40);
					setting.round_gap_ms       = $urandom_range(1, 60);
					setting.short_burst_pulses = $urandom_range(1, 15);
					setting.long_burst_pulses  = $urandom_range(1, 15);
					setting.call_rounds        = $urandom_range(1, 15);
					setting.idle_rounds        = $urandom_range(1, 15);
					setting.hr_rounds          = $urandom_range(1, 15);
				end
			endcase
			// Upper data bits are random: the block must keep only the register width.
			apb_write(REG_ON_TIME,     {16'($urandom), setting.on_time_ms});
			apb_write(REG_OFF_TIME,    {16'($urandom), setting.off_time_ms});
			apb_write(REG_ROUND_GAP,   {16'($urandom), setting.round_gap_ms});
			apb_write(REG_SHORT_BURST, {28'($urandom), setting.short_burst_pulses});
			apb_write(REG_LONG_BURST,  {28'($urandom), setting.long_burst_pulses});
			apb_write(REG_CALL_ROUNDS, {28'($urandom), setting.call_rounds});
			apb_write(REG_IDLE_ROUNDS, {28'($urandom), setting.idle_rounds});
			apb_write(REG_HR_ROUNDS,   {28'($urandom), setting.hr_rounds});

			// The slow setting starts just short of the wrap so that long
			// timeouts are measured across it.
			clock_ms = (p == 3) ? 32'hFFFF_0000 : $urandom;

			for (n = 0; n < WORDS_PER_SETTING; n++) begin
				// Flags that a word does not use still toggle at random.
				w.update_mode   = 1'b0;
				w.incoming_call = $urandom_range(0, 1);
				w.worn          = $urandom_range(0, 1);
				w.asleep        = $urandom_range(0, 1);
				w.now_ms        = clock_ms;
				// Starts are common while idle and rare while a pattern runs, so
				// most patterns get to play out through their rounds.
				start_pct = (seq.phase != PH_IDLE) ? 3 : 30;
				pick = $urandom_range(0, 99);
				if (pick < start_pct) begin
					case ($urandom_range(0, 2))
						0: begin
							w.func = FN_MSG;
							// Mostly a message that is allowed to buzz.
							if ($urandom_range(0, 3) != 0) begin
								w.worn   = 1'b1;
								w.asleep = 1'b0;
							end
						end
						1:       w.func = FN_IDLE;
						default: w.func = FN_HR;
					endcase
					w.update_mode = ($urandom_range(0, 4) == 0);
				end else if (pick < start_pct + 3) begin
					w.func        = FN_STOP;
					w.update_mode = $urandom_range(0, 1);
				end else if (pick < start_pct + 6) begin
					w.func        = FN_TICK;
					w.update_mode = 1'b1;
				end else if (pick < start_pct + 8) begin
					w.func        = $urandom_range(FN_UNUSED_LO, FN_UNUSED_HI);
					w.now_ms      = $urandom;
					w.update_mode = $urandom_range(0, 1);
				end else if (pick < start_pct + 10) begin
					// Noise: a tick with a time from nowhere.
					w.func   = FN_TICK;
					w.now_ms = $urandom;
				end else begin
					// Well-formed tick. Time moves forward in small steps, or
					// jumps to just at or just past the running timeout so that
					// the strict compare is exercised on both sides.
					w.func = FN_TICK;
					case (seq.phase)
						PH_ON:   thr = {16'd0, timing_cfg.on_time_ms};
						PH_OFF:  thr = {16'd0, timing_cfg.off_time_ms};
						PH_GAP:  thr = {16'd0, timing_cfg.round_gap_ms};
						default: thr = 32'd0;
					endcase
					pick = $urandom_range(0, 9);
					if (pick < 4) begin
						clock_ms = clock_ms + $urandom_range(0, thr / 3 + 1);
					end else if (pick < 7) begin
						target = seq.stamp_ms + thr + $urandom_range(0, 1);
						diff   = target - clock_ms;
						clock_ms = diff[31] ? clock_ms + 32'd1 : target;
					end else begin
						clock_ms = clock_ms + $urandom_range(0, 3);
					end
					w.now_ms = clock_ms;
				end
				send_word(w, 1'b0, '0);
				// Once in the run, the output side holds off long enough to
				// back the block up while words keep being offered.
				if (p == 0 && n == WORDS_PER_SETTING / 2) hold_req = 1'b1;
			end
			drain_outputs();
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
